// ===== rtl/assert_macros.svh =====
// Assertion macros used by the unpacker top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK_RST(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RST(name, prop, msg)

`define ASSERT_CLK(name, prop, msg)

`endif

`endif

// ===== rtl/rbsu_pkg.sv =====
package rbsu_pkg;

  localparam int SAMPLE_W    = 40;
  localparam int BYTE_W      = 8;
  localparam int FMT_W       = 3;
  localparam int POS_W       = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [FMT_W-1:0] FMT_INT8  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_INT16 = 3'd1;
  localparam logic [FMT_W-1:0] FMT_INT24 = 3'd2;
  localparam logic [FMT_W-1:0] FMT_INT32 = 3'd3;
  localparam logic [FMT_W-1:0] FMT_INT40 = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] first;
    logic signed [SAMPLE_W-1:0] second;
  } pair_t;

  typedef struct packed {
    logic             half;
    logic [POS_W-1:0] pos;
  } front_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [POS_W-1:0] bytes_per_sample(logic [FMT_W-1:0] fmt);
    logic [POS_W-1:0] nb;
    unique case (fmt)
      FMT_INT8:  nb = 3'd1;
      FMT_INT16: nb = 3'd2;
      FMT_INT24: nb = 3'd3;
      FMT_INT32: nb = 3'd4;
      FMT_INT40: nb = 3'd5;
      default:   nb = 3'd0;
    endcase
    return nb;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sign_extend(logic [SAMPLE_W-1:0] raw,
                                                            logic [POS_W-1:0] nb);
    logic signed [SAMPLE_W-1:0] res;
    case (nb)
      3'd1:    res = {{32{raw[7]}}, raw[7:0]};
      3'd2:    res = {{24{raw[15]}}, raw[15:0]};
      3'd3:    res = {{16{raw[23]}}, raw[23:0]};
      3'd4:    res = {{8{raw[31]}}, raw[31:0]};
      default: res = raw;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/rbsu_front.sv =====
module rbsu_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rbsu_pkg::FMT_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rbsu_pkg::BYTE_W-1:0] data_byte,
  input  rbsu_pkg::queue_status_t     queue_status,
  output logic                        push,
  output rbsu_pkg::pair_t             push_pair,
  output rbsu_pkg::front_status_t     status
);
  import rbsu_pkg::*;

  logic [FMT_W-1:0]    sample_format;
  logic [POS_W-1:0]    pos;
  logic                half;
  logic [SAMPLE_W-1:0] acc;
  logic [SAMPLE_W-1:0] acc_next;
  logic signed [SAMPLE_W-1:0] first;
  logic signed [SAMPLE_W-1:0] done_sample;
  logic [POS_W-1:0]    nb;
  logic                little;
  logic                accept;
  logic                known;
  logic                done;
  logic [SAMPLE_W-1:0] byte_ext;

  assign nb       = bytes_per_sample(sample_format);
  assign known    = (nb != 3'd0);
  assign little   = (sample_format == FMT_INT16) || (sample_format == FMT_INT32);
  assign in_stall = queue_status.full;
  assign accept   = in_valid && !in_stall;
  assign done     = (pos == nb - 3'd1);
  assign byte_ext = {{(SAMPLE_W-BYTE_W){1'b0}}, data_byte};

  always_comb begin
    if (pos == 3'd0) begin
      acc_next = byte_ext;
    end else if (little) begin
      acc_next = acc | (byte_ext << {pos, 3'b000});
    end else begin
      acc_next = {acc[SAMPLE_W-BYTE_W-1:0], data_byte};
    end
  end

  assign done_sample = sign_extend(acc_next, nb);
  assign push        = accept && known && done && half;
  assign push_pair   = '{first: first, second: done_sample};
  assign status      = '{half: half, pos: pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_INT16;
      pos           <= '0;
      half          <= 1'b0;
    end else if (cfg_write) begin
      sample_format <= cfg_data;
      pos           <= '0;
      half          <= 1'b0;
    end else if (accept && known) begin
      if (done) begin
        pos  <= '0;
        half <= !half;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && known) begin
      acc <= acc_next;
      if (done && !half) begin
        first <= done_sample;
      end
    end
  end

endmodule

// ===== rtl/rbsu_queue.sv =====
module rbsu_queue #(
  parameter int DEPTH = rbsu_pkg::QUEUE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rbsu_pkg::pair_t         push_pair,
  input  logic                    pop,
  output rbsu_pkg::pair_t         head,
  output rbsu_pkg::queue_status_t status
);
  import rbsu_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pair_t              slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + PTR_W'(1);
    end
    return n;
  endfunction

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pair;
    end
  end

endmodule

// ===== rtl/rbsu_back.sv =====
module rbsu_back (
  input  logic                                clk,
  input  logic                                rst,
  input  rbsu_pkg::pair_t                     head,
  input  rbsu_pkg::queue_status_t             queue_status,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rbsu_pkg::SAMPLE_W-1:0] sample,
  output logic                                last
);
  import rbsu_pkg::*;

  logic half;
  logic out_accept;

  assign out_valid  = !queue_status.empty;
  assign out_accept = out_valid && !out_stall;
  assign sample     = half ? head.second : head.first;
  assign last       = half;
  assign pop        = out_accept && half;

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
    end else if (out_accept) begin
      half <= !half;
    end
  end

endmodule

// ===== rtl/raw_byte_to_sample_unpacker.sv =====
// Gathers a raw byte stream into sign-extended 40-bit samples (int8, int16 LE, int24 BE,
// int32 LE or int40 BE) and releases them in pairs, the second one flagged by last.
// One byte is taken every clock unless the queue is full; a completed pair goes into a
// two-entry pair queue and the output side delivers its two samples on consecutive
// unstalled cycles, so the output keeps up with the densest case (int8, one sample per
// byte). A byte completes a pair in the cycle it is taken and its pair can be shown in
// the next cycle. Bytes under an unknown format code are taken and dropped. Writing the
// format register drops any partial pair; write it only while the block is idle.
`include "assert_macros.svh"

module raw_byte_to_sample_unpacker #(
  parameter int QUEUE_DEPTH = rbsu_pkg::QUEUE_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rbsu_pkg::FMT_W-1:0]           cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [rbsu_pkg::BYTE_W-1:0]          data_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [rbsu_pkg::SAMPLE_W-1:0] sample,
  output logic                                 last
);
  import rbsu_pkg::*;

  logic          push;
  logic          pop;
  pair_t         push_pair;
  pair_t         head;
  queue_status_t queue_status;
  front_status_t front_status;
  logic          cfg_write;
  logic          out_take;
  logic          front_idle;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign out_take   = out_valid && !out_stall;
  assign front_idle = (front_status.pos == '0) && !front_status.half;

  rbsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .queue_status (queue_status),
    .push         (push),
    .push_pair    (push_pair),
    .status       (front_status)
  );

  rbsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_pair (push_pair),
    .pop       (pop),
    .head      (head),
    .status    (queue_status)
  );

  rbsu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .queue_status (queue_status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sample       (sample),
    .last         (last)
  );

  `ASSERT_CLK_RST(a_no_overflow, push |-> !queue_status.full, "Pair pushed into a full queue.")
  `ASSERT_CLK_RST(a_pair_second, (out_take && !last) |=> (out_valid && last), "Pair is cut short.")
  `ASSERT_CLK_RST(a_cfg_clears, cfg_write |=> front_idle, "Partial pair survived a format write.")

endmodule
